// ----- rtl/jebf_pkg.sv -----
// Shared constants and types for the JSON element boundary framer.
package jebf_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [7:0] CH_OBJ_OPEN  = 8'h7B;
    localparam logic [7:0] CH_ARR_OPEN  = 8'h5B;
    localparam logic [7:0] CH_OBJ_CLOSE = 8'h7D;
    localparam logic [7:0] CH_ARR_CLOSE = 8'h5D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    localparam logic [1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [1:0] ST_COMPLETE   = 2'd1;
    localparam logic [1:0] ST_ERROR      = 2'd2;

    localparam logic KIND_OBJ = 1'b0;
    localparam logic KIND_ARR = 1'b1;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] nesting_level;
        logic       inside_string;
    } t_result;

endpackage

// ----- rtl/jebf_stack_mem.sv -----
// Bracket kind stack memory: one write port, one registered read port with write bypass.
module jebf_stack_mem
    import jebf_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [STACK_DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/jebf_scan.sv -----
// Byte scanner: escape and string flags, stack level, top-of-stack register, stack access.
module jebf_scan
    import jebf_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
    localparam int LW = $clog2(STACK_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_second,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic          o_wdata,
    output logic [AW-1:0] o_raddr,
    output t_result       o_result
);

    logic          r_escape;
    logic          r_string;
    logic [LW-1:0] r_level;
    logic          r_top;

    logic          n_escape;
    logic          n_string;
    logic [LW-1:0] n_level;
    logic          n_top;
    logic [1:0]    n_status;
    logic          push;
    logic [LW-1:0] waddr_full;
    logic [LW-1:0] raddr_full;
    logic [31:0]   level_ext;

    localparam logic [LW-1:0] LEVEL_MAX = LW'(STACK_DEPTH);

    always_comb begin
        n_escape = r_escape;
        n_string = r_string;
        n_level  = r_level;
        n_top    = r_top;
        n_status = ST_INCOMPLETE;
        push     = 1'b0;
        if (r_escape) begin
            n_escape = 1'b0;
        end else if (i_byte == CH_BACKSLASH) begin
            n_escape = 1'b1;
        end else if (i_byte == CH_QUOTE) begin
            n_string = !r_string;
        end else if (!r_string) begin
            if ((i_byte == CH_OBJ_OPEN) || (i_byte == CH_ARR_OPEN)) begin
                if (r_level == LEVEL_MAX) begin
                    n_status = ST_ERROR;
                end else begin
                    push    = (r_level != '0);
                    n_top   = (i_byte == CH_ARR_OPEN) ? KIND_ARR : KIND_OBJ;
                    n_level = r_level + LW'(1);
                end
            end else if ((i_byte == CH_OBJ_CLOSE) || (i_byte == CH_ARR_CLOSE)) begin
                if (r_level == '0) begin
                    n_status = ST_ERROR;
                end else begin
                    n_level = r_level - LW'(1);
                    n_top   = i_second;
                    if (r_top != ((i_byte == CH_ARR_CLOSE) ? KIND_ARR : KIND_OBJ)) begin
                        n_status = ST_ERROR;
                    end else if (n_level == '0) begin
                        n_status = ST_COMPLETE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape <= 1'b0;
            r_string <= 1'b0;
            r_level  <= '0;
        end else if (i_accept) begin
            r_escape <= n_escape;
            r_string <= n_string;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_top <= n_top;
        end
    end

    assign waddr_full = r_level - LW'(1);
    assign raddr_full = (i_accept ? n_level : r_level) - LW'(2);
    assign level_ext  = 32'(n_level);

    assign o_we    = i_accept && push;
    assign o_waddr = waddr_full[AW-1:0];
    assign o_wdata = r_top;
    assign o_raddr = raddr_full[AW-1:0];

    assign o_result.status        = n_status;
    assign o_result.nesting_level = level_ext[6:0];
    assign o_result.inside_string = n_string;

endmodule

// ----- rtl/json_element_boundary_framer.sv -----
// Top level of the JSON element boundary framer: scanner, stack memory and output register.
//
// Channel  Dir  Handshake                 Payload
// in       in   i_in_valid / o_in_stall   i_data_byte
// out      out  o_out_valid / i_out_stall o_status, o_echo_byte, o_nesting_level,
//                                         o_inside_string
//
// One byte per cycle while the output is not stalled, one result per byte, held in the output register.
// The top stack entry sits in a register; the entry below it is read ahead from the stack
// memory, so a close in every cycle runs at full rate.
// Synchronous active-low reset clears the flags, the stack level and the output valid.
// The input stalls only while a held result is stalled at the output.
module json_element_boundary_framer
    import jebf_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_echo_byte,
    output logic [6:0] o_nesting_level,
    output logic       o_inside_string
);

    logic          accept;
    logic          we;
    logic [AW-1:0] waddr;
    logic          wdata;
    logic [AW-1:0] raddr;
    logic          second;
    t_result       result;

    logic          r_out_valid;
    t_result       r_result;
    logic [7:0]    r_echo;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    jebf_scan #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_data_byte),
        .i_second (second),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_raddr  (raddr),
        .o_result (result)
    );

    jebf_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= accept || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
            r_echo   <= i_data_byte;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_result.status;
    assign o_echo_byte     = r_echo;
    assign o_nesting_level = r_result.nesting_level;
    assign o_inside_string = r_result.inside_string;

endmodule
